/* hdl/ehs_pkg.sv */
// shared types, constants and saturation helpers for the epileptor heun step
`timescale 1ns / 1ps

package ehs_pkg;

    // fixed point word, 48 bit signed
    typedef logic signed [47:0] t_q;
    typedef t_q t_six [6];

    typedef struct packed {
        t_q   v;
        logic o;
    } t_sr;

    typedef enum logic [2:0] {
        CFG_TIME_STEP     = 3'd0,
        CFG_EXCITABILITY  = 3'd1,
        CFG_DRIVE_FIRST   = 3'd2,
        CFG_DRIVE_SECOND  = 3'd3,
        CFG_SLOW_COUPLING = 3'd4
    } t_cfg_idx;

    localparam int FRAC_DEF = 32;
    // pipelined multiplier: abs, partial products, sum, round and saturate
    localparam int MUL_LAT  = 4;
    // derivative unit: longest chain is eight products, plus the output register
    localparam int DER_LAT  = 8 * MUL_LAT + 1;

    localparam logic [32:0] RST_TIME_STEP     = 33'd214748365;
    localparam logic [35:0] RST_EXCITABILITY  = 36'hE80000000;
    localparam logic [35:0] RST_DRIVE_FIRST   = 36'h31999999A;
    localparam logic [35:0] RST_DRIVE_SECOND  = 36'h073333333;
    localparam logic [35:0] RST_SLOW_COUPLING = 36'h180000000;

    function automatic logic signed [51:0] ext52(input t_q x);
        return $signed({{4{x[47]}}, x});
    endfunction

    function automatic t_q ext36(input logic signed [35:0] x);
        return $signed({{12{x[35]}}, x});
    endfunction

    function automatic logic signed [48:0] ext49(input t_q x);
        return $signed({x[47], x});
    endfunction

    function automatic t_sr sat48(input logic signed [51:0] x);
        t_sr r;
        if (x[51:47] != {5{x[51]}}) begin
            r.o = 1'b1;
            r.v = x[51] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
        end else begin
            r.o = 1'b0;
            r.v = x[47:0];
        end
        return r;
    endfunction

endpackage

/* hdl/ehs_dly.sv */
// enable-gated delay line of fixed depth
`timescale 1ns / 1ps

module ehs_dly #(
    parameter int W = 48,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    generate
        if (D == 0) begin : g_none
            assign o_q = i_d;
        end else begin : g_sh
            logic [W-1:0] r_sh [D];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sh[0] <= i_d;
                    for (int k = 1; k < D; k++) begin
                        r_sh[k] <= r_sh[k-1];
                    end
                end
            end
            assign o_q = r_sh[D-1];
        end
    endgenerate

endmodule

/* hdl/ehs_mul.sv */
// four stage signed fixed point multiplier, round half up, saturate to 48 bits
`timescale 1ns / 1ps

module ehs_mul #(
    parameter int W  = 48,
    parameter int SH = 32
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic signed [47:0]  o_p,
    output logic                o_ovf
);

    localparam int HL = (W + 1) / 2;
    localparam int HH = W - HL;
    localparam int PW = 2 * W;
    localparam int RW = PW + 2;
    localparam int QW = RW - SH;
    localparam logic [RW-1:0] C_HALF = {{(RW-1){1'b0}}, 1'b1} << (SH - 1);

    logic [W-1:0]       r_ma, r_mb;
    logic               r_s1, r_s2, r_s3;
    logic [2*HL-1:0]    r_ll;
    logic [HL+HH-1:0]   r_lh, r_hl;
    logic [2*HH-1:0]    r_hh;
    logic [PW-1:0]      r_mag;
    logic [RW-1:0]      w_v;
    logic [QW-1:0]      w_q;
    logic               w_ovf;
    logic signed [47:0] r_p;
    logic               r_o;

    // rounding add folded into the negation: h - mag or mag + h
    assign w_v   = r_s3 ? (C_HALF - RW'(r_mag)) : (RW'(r_mag) + C_HALF);
    assign w_q   = w_v[RW-1:SH];
    assign w_ovf = (w_q[QW-1:47] != {(QW-47){w_q[47]}});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma <= i_a[W-1] ? W'(-i_a) : W'(i_a);
            r_mb <= i_b[W-1] ? W'(-i_b) : W'(i_b);
            r_s1 <= i_a[W-1] ^ i_b[W-1];
            r_ll <= r_ma[HL-1:0] * r_mb[HL-1:0];
            r_lh <= r_ma[HL-1:0] * r_mb[W-1:HL];
            r_hl <= r_ma[W-1:HL] * r_mb[HL-1:0];
            r_hh <= r_ma[W-1:HL] * r_mb[W-1:HL];
            r_s2 <= r_s1;
            r_mag <= PW'(r_ll) + (PW'(r_lh) << HL) + (PW'(r_hl) << HL)
                   + (PW'(r_hh) << (2 * HL));
            r_s3 <= r_s2;
            if (w_ovf) begin
                r_p <= w_q[QW-1] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
            end else begin
                r_p <= w_q[47:0];
            end
            r_o <= w_ovf;
        end
    end

    assign o_p   = r_p;
    assign o_ovf = r_o;

endmodule

/* hdl/ehs_deriv.sv */
// pipelined epileptor derivative of six state variables
`timescale 1ns / 1ps

module ehs_deriv import ehs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  t_six               i_y,
    input  t_q                 i_c1,
    input  logic signed [35:0] i_x0,
    input  logic signed [35:0] i_iext,
    input  logic signed [35:0] i_iext2,
    input  logic signed [35:0] i_ks,
    output t_six               o_d,
    output logic               o_ovf
);

    localparam int ML = MUL_LAT;
    localparam longint L06  = ((longint'(6) << (FRAC_BITS + 1)) + 10) / 20;
    localparam longint L03  = ((longint'(3) << (FRAC_BITS + 1)) + 10) / 20;
    localparam longint L01  = ((longint'(1) << (FRAC_BITS + 1)) + 10) / 20;
    localparam longint L001 = ((longint'(1) << (FRAC_BITS + 1)) + 100) / 200;
    localparam longint LR   = ((longint'(35) << (FRAC_BITS + 1)) + 100000) / 200000;
    localparam t_q K06  = 48'(L06);
    localparam t_q K03  = 48'(L03);
    localparam t_q K01  = 48'(L01);
    localparam t_q K001 = 48'(L001);
    localparam t_q KR   = 48'(LR);
    localparam logic signed [51:0] C_ONE  = 52'(longint'(1) << FRAC_BITS);
    localparam logic signed [51:0] C_FOUR = 52'(longint'(4) << FRAC_BITS);
    localparam logic signed [51:0] C_3P5  = 52'(longint'(7) << (FRAC_BITS - 1));
    localparam logic signed [51:0] C_QTR  = 52'(longint'(1) << (FRAC_BITS - 2));

    t_q y0, y1, y2, y3, y4, y5, ks48;

    // entry terms
    t_sr s_3y, s_p, s_ny3, s_a01, s_a02, s_u, s_4u, s_a2, s_b1, s_b2, s_2y5, s_h;
    t_sr s_q, s_6q, s_d4in;
    t_q  g_sel;
    logic y0n, y2n, y3lo, f_t0;

    // products
    t_q  m_yy, m_pp, m_ksc, m_y3sq, m_hk, m_d4, m_k01y0, m_q6, m_cube, m_r5;
    t_q  m_tm, m_k01p, m_kr;
    logic o_yy, o_pp, o_ksc, o_y3sq, o_hk, o_d4, o_k01y0, o_q6, o_cube, o_r5;
    logic o_tm, o_k01p, o_kr;
    t_q   m_p [1:6];
    logic o_p [1:6];

    // delayed operands
    t_q y0_1, y0_2, y1_1, y3_1, y5_1, d3y_1, tn_2, ny3_2, b2_2, s2y5_2, hk_2;
    t_q a02_3, a2_7, ksc_7;
    t_q y2_t [0:5];
    logic y2n_t [0:7];
    logic y0n_1, y0n_2;

    // later terms
    t_sr s_tn, s_5, s_w, s_d1, s_v5, s_tp, s_c1, s_c2, s_c3, s_c4, s_d5, s_d0;
    t_sr s_tn7, s_aa, s_ab;
    t_q  t_sel, t_tt;

    logic f_add [1:8];
    logic f_acc [0:7];
    logic f_end;
    t_q   d0_o, d1_o, d3_o, d4_o, d5_o;
    t_six r_d;
    logic r_ovf;

    assign y0 = i_y[0];
    assign y1 = i_y[1];
    assign y2 = i_y[2];
    assign y3 = i_y[3];
    assign y4 = i_y[4];
    assign y5 = i_y[5];
    assign ks48 = ext36(i_ks);

    always_comb begin
        y0n    = y0[47];
        y2n    = y2[47];
        s_3y   = sat48(ext52(y0) + (ext52(y0) <<< 1));
        s_p    = sat48(ext52(y2) - C_FOUR);
        s_ny3  = sat48(-ext52(y3));
        s_a01  = sat48(ext52(y1) - ext52(y2));
        s_a02  = sat48(ext52(s_a01.v) + ext52(ext36(i_iext)));
        s_u    = sat48(ext52(y0) - ext52(ext36(i_x0)));
        s_4u   = sat48(ext52(s_u.v) <<< 2);
        s_a2   = sat48(ext52(s_4u.v) - ext52(y2));
        s_b1   = sat48(-ext52(y4));
        s_b2   = sat48(ext52(s_b1.v) + ext52(y3));
        s_2y5  = sat48(ext52(y5) <<< 1);
        s_h    = sat48(ext52(y2) - C_3P5);
        y3lo   = ext52(y3) < -C_QTR;
        s_q    = sat48(ext52(y3) + C_QTR);
        s_6q   = sat48((ext52(s_q.v) <<< 2) + (ext52(s_q.v) <<< 1));
        g_sel  = y3lo ? '0 : s_6q.v;
        s_d4in = sat48(ext52(s_b1.v) + ext52(g_sel));
        f_t0   = s_a01.o | s_a02.o | s_u.o | s_4u.o | s_a2.o | s_b1.o | s_b2.o
               | s_2y5.o | s_h.o | s_d4in.o | (!y3lo & (s_q.o | s_6q.o))
               | (y0n ? s_3y.o : (s_p.o | s_ny3.o));
    end

    // first products, all from entry values
    ehs_mul #(.W(48), .SH(FRAC_BITS)) u_yy (
        .i_clk, .i_en, .i_a(y0), .i_b(y0), .o_p(m_yy), .o_ovf(o_yy));
    ehs_mul #(.W(48), .SH(FRAC_BITS)) u_pp (
        .i_clk, .i_en, .i_a(s_p.v), .i_b(s_p.v), .o_p(m_pp), .o_ovf(o_pp));
    ehs_mul #(.W(48), .SH(FRAC_BITS)) u_ksc (
        .i_clk, .i_en, .i_a(ks48), .i_b(i_c1), .o_p(m_ksc), .o_ovf(o_ksc));
    ehs_mul #(.W(48), .SH(FRAC_BITS)) u_p1 (
        .i_clk, .i_en, .i_a(y2), .i_b(y2), .o_p(m_p[1]), .o_ovf(o_p[1]));
    ehs_mul #(.W(48), .SH(FRAC_BITS)) u_y3sq (
        .i_clk, .i_en, .i_a(y3), .i_b(y3), .o_p(m_y3sq), .o_ovf(o_y3sq));
    ehs_mul #(.W(48), .SH(FRAC_BITS)) u_hk (
        .i_clk, .i_en, .i_a(K03), .i_b(s_h.v), .o_p(m_hk), .o_ovf(o_hk));
    ehs_mul #(.W(48), .SH(FRAC_BITS)) u_d4 (
        .i_clk, .i_en, .i_a(K01), .i_b(s_d4in.v), .o_p(m_d4), .o_ovf(o_d4));
    ehs_mul #(.W(48), .SH(FRAC_BITS)) u_k01y0 (
        .i_clk, .i_en, .i_a(K01), .i_b(y0), .o_p(m_k01y0), .o_ovf(o_k01y0));

    ehs_dly #(.W(48), .D(ML))     u_dy0a (.i_clk, .i_en, .i_d(y0), .o_q(y0_1));
    ehs_dly #(.W(48), .D(ML))     u_dy0b (.i_clk, .i_en, .i_d(y0_1), .o_q(y0_2));
    ehs_dly #(.W(48), .D(ML))     u_dy1 (.i_clk, .i_en, .i_d(y1), .o_q(y1_1));
    ehs_dly #(.W(48), .D(ML))     u_dy3 (.i_clk, .i_en, .i_d(y3), .o_q(y3_1));
    ehs_dly #(.W(48), .D(ML))     u_dy5 (.i_clk, .i_en, .i_d(y5), .o_q(y5_1));
    ehs_dly #(.W(48), .D(ML))     u_d3y (.i_clk, .i_en, .i_d(s_3y.v), .o_q(d3y_1));
    ehs_dly #(.W(48), .D(2 * ML)) u_dny3 (.i_clk, .i_en, .i_d(s_ny3.v), .o_q(ny3_2));
    ehs_dly #(.W(48), .D(2 * ML)) u_db2 (.i_clk, .i_en, .i_d(s_b2.v), .o_q(b2_2));
    ehs_dly #(.W(48), .D(2 * ML)) u_d2y5 (.i_clk, .i_en, .i_d(s_2y5.v), .o_q(s2y5_2));
    ehs_dly #(.W(48), .D(3 * ML)) u_da02 (.i_clk, .i_en, .i_d(s_a02.v), .o_q(a02_3));
    ehs_dly #(.W(48), .D(7 * ML)) u_da2 (.i_clk, .i_en, .i_d(s_a2.v), .o_q(a2_7));
    ehs_dly #(.W(1), .D(ML))      u_dn0a (.i_clk, .i_en, .i_d(y0n), .o_q(y0n_1));
    ehs_dly #(.W(1), .D(ML))      u_dn0b (.i_clk, .i_en, .i_d(y0n_1), .o_q(y0n_2));

    assign y2_t[0]  = y2;
    assign y2n_t[0] = y2n;

    // seventh power of the energy: six products in a row
    genvar k;
    generate
        for (k = 1; k <= 5; k++) begin : g_y2
            ehs_dly #(.W(48), .D(ML)) u_dy2 (
                .i_clk, .i_en, .i_d(y2_t[k-1]), .o_q(y2_t[k]));
            ehs_mul #(.W(48), .SH(FRAC_BITS)) u_pk (
                .i_clk, .i_en, .i_a(m_p[k]), .i_b(y2_t[k]),
                .o_p(m_p[k+1]), .o_ovf(o_p[k+1]));
        end
        for (k = 1; k <= 7; k++) begin : g_y2n
            ehs_dly #(.W(1), .D(ML)) u_dn2 (
                .i_clk, .i_en, .i_d(y2n_t[k-1]), .o_q(y2n_t[k]));
        end
    endgenerate

    // terms that follow the first products
    always_comb begin
        s_tn = sat48(ext52(d3y_1) - ext52(m_yy));
        s_5  = sat48((ext52(m_yy) <<< 2) + ext52(m_yy));
        s_w  = sat48(C_ONE - ext52(s_5.v));
        s_d1 = sat48(ext52(s_w.v) - ext52(y1_1));
        s_v5 = sat48(ext52(y5_1) - ext52(m_k01y0));
    end

    ehs_dly #(.W(48), .D(ML))     u_dtn (.i_clk, .i_en, .i_d(s_tn.v), .o_q(tn_2));
    ehs_dly #(.W(48), .D(ML))     u_dhk (.i_clk, .i_en, .i_d(m_hk), .o_q(hk_2));
    ehs_dly #(.W(48), .D(6 * ML)) u_dksc (.i_clk, .i_en, .i_d(m_ksc), .o_q(ksc_7));

    ehs_mul #(.W(48), .SH(FRAC_BITS)) u_q6 (
        .i_clk, .i_en, .i_a(K06), .i_b(m_pp), .o_p(m_q6), .o_ovf(o_q6));
    ehs_mul #(.W(48), .SH(FRAC_BITS)) u_cube (
        .i_clk, .i_en, .i_a(m_y3sq), .i_b(y3_1), .o_p(m_cube), .o_ovf(o_cube));
    ehs_mul #(.W(48), .SH(FRAC_BITS)) u_r5 (
        .i_clk, .i_en, .i_a(K001), .i_b(s_v5.v), .o_p(m_r5), .o_ovf(o_r5));

    // terms that follow the second products
    always_comb begin
        s_tp  = sat48(ext52(ny3_2) + ext52(m_q6));
        t_sel = y0n_2 ? tn_2 : s_tp.v;
        s_c1  = sat48(ext52(b2_2) - ext52(m_cube));
        s_c2  = sat48(ext52(s_c1.v) + ext52(ext36(i_iext2)));
        s_c3  = sat48(ext52(s_c2.v) + ext52(s2y5_2));
        s_c4  = sat48(ext52(s_c3.v) - ext52(hk_2));
        s_d5  = sat48(-ext52(m_r5));
    end

    ehs_mul #(.W(48), .SH(FRAC_BITS)) u_tm (
        .i_clk, .i_en, .i_a(t_sel), .i_b(y0_2), .o_p(m_tm), .o_ovf(o_tm));

    assign s_d0 = sat48(ext52(a02_3) + ext52(m_tm));

    ehs_mul #(.W(48), .SH(FRAC_BITS)) u_k01p (
        .i_clk, .i_en, .i_a(K01), .i_b(m_p[6]), .o_p(m_k01p), .o_ovf(o_k01p));

    always_comb begin
        s_tn7 = sat48(-ext52(m_k01p));
        t_tt  = y2n_t[7] ? s_tn7.v : '0;
        s_aa  = sat48(ext52(a2_7) + ext52(t_tt));
        s_ab  = sat48(ext52(s_aa.v) + ext52(ksc_7));
    end

    ehs_mul #(.W(48), .SH(FRAC_BITS)) u_kr (
        .i_clk, .i_en, .i_a(KR), .i_b(s_ab.v), .o_p(m_kr), .o_ovf(o_kr));

    // saturation flags, folded in where each term lives
    always_comb begin
        f_add[1] = o_yy | s_5.o | s_w.o | s_d1.o | o_ksc | o_y3sq | o_hk | o_d4
                 | o_k01y0 | s_v5.o | (y0n_1 ? s_tn.o : o_pp) | (y2n_t[1] & o_p[1]);
        f_add[2] = (!y0n_2 & (o_q6 | s_tp.o)) | o_cube | s_c1.o | s_c2.o | s_c3.o
                 | s_c4.o | o_r5 | s_d5.o | (y2n_t[2] & o_p[2]);
        f_add[3] = o_tm | s_d0.o | (y2n_t[3] & o_p[3]);
        f_add[4] = y2n_t[4] & o_p[4];
        f_add[5] = y2n_t[5] & o_p[5];
        f_add[6] = y2n_t[6] & o_p[6];
        f_add[7] = (y2n_t[7] & (o_k01p | s_tn7.o)) | s_aa.o | s_ab.o;
        f_add[8] = o_kr;
    end

    assign f_acc[0] = f_t0;
    generate
        for (k = 1; k <= 7; k++) begin : g_flag
            logic w_fd;
            ehs_dly #(.W(1), .D(ML)) u_df (
                .i_clk, .i_en, .i_d(f_acc[k-1]), .o_q(w_fd));
            assign f_acc[k] = w_fd | f_add[k];
        end
    endgenerate

    ehs_dly #(.W(1), .D(ML)) u_dfe (.i_clk, .i_en, .i_d(f_acc[7]), .o_q(f_end));

    // align every derivative to the slowest one
    ehs_dly #(.W(48), .D(5 * ML)) u_od0 (.i_clk, .i_en, .i_d(s_d0.v), .o_q(d0_o));
    ehs_dly #(.W(48), .D(7 * ML)) u_od1 (.i_clk, .i_en, .i_d(s_d1.v), .o_q(d1_o));
    ehs_dly #(.W(48), .D(6 * ML)) u_od3 (.i_clk, .i_en, .i_d(s_c4.v), .o_q(d3_o));
    ehs_dly #(.W(48), .D(7 * ML)) u_od4 (.i_clk, .i_en, .i_d(m_d4), .o_q(d4_o));
    ehs_dly #(.W(48), .D(6 * ML)) u_od5 (.i_clk, .i_en, .i_d(s_d5.v), .o_q(d5_o));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= d0_o;
            r_d[1] <= d1_o;
            r_d[2] <= m_kr;
            r_d[3] <= d3_o;
            r_d[4] <= d4_o;
            r_d[5] <= d5_o;
            r_ovf  <= f_end | f_add[8];
        end
    end

    assign o_d   = r_d;
    assign o_ovf = r_ovf;

endmodule

/* hdl/epileptor_heun_step.sv */
// top level: one heun step of an epileptor node, fully pipelined
//
// channel  dir  handshake                          payload
// s_axis   in   i_s_axis_tvalid / o_s_axis_tready  i_s_axis_tdata, 8 x 48 bit state and coupling
// m_axis   out  o_m_axis_tvalid / i_m_axis_tready  o_m_axis_tdata, 6 x 48 bit state and overflow
// cfg      in   i_cfg_valid / o_cfg_ready          i_cfg_index, i_cfg_data
//
// one transaction per cycle while the pipeline advances; the path runs through the two derivative
// evaluations and the predictor and corrector multipliers
// the whole pipeline advances while the output register is empty or being taken
// synchronous active-low reset clears the valid bits and loads the register defaults
`timescale 1ns / 1ps

module epileptor_heun_step import ehs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // x_one, y_one, energy, x_two, y_two, lowpass, coupling_first, coupling_second
    input  logic [383:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // next_x_one, next_y_one, next_energy, next_x_two, next_y_two, next_lowpass,
    // overflow, zero fill
    output logic [295:0] o_m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [35:0]  i_cfg_data
);

    localparam int ML  = MUL_LAT;
    localparam int TE  = DER_LAT + ML + 1;
    localparam int TOT = TE + DER_LAT + ML;

    logic               w_en;
    logic               r_in_vld, r_out_vld, r_ovf;
    logic               r_vp [TOT];
    t_six               r_y, r_e, r_next;
    t_q                 r_c1;
    logic               r_pf;
    logic [32:0]        r_dt;
    logic signed [35:0] r_x0, r_iext, r_iext2, r_ks;
    logic signed [48:0] w_dt49;

    t_six dl, dr, y_p, y_c, dl_d;
    t_q   c1_e;
    logic f_d1, f_d1d, f_pd, f_cd;
    t_q   p_prod [6];
    logic p_o [6];
    t_q   c_prod [6];
    logic c_o [6];
    t_sr  s_e [6];
    t_sr  s_n [6];
    logic f_pred, f_corr;

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_cfg_ready     = 1'b1;
    assign w_dt49          = $signed({16'd0, r_dt});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt    <= RST_TIME_STEP;
            r_x0    <= RST_EXCITABILITY;
            r_iext  <= RST_DRIVE_FIRST;
            r_iext2 <= RST_DRIVE_SECOND;
            r_ks    <= RST_SLOW_COUPLING;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TIME_STEP:     r_dt    <= i_cfg_data[32:0];
                CFG_EXCITABILITY:  r_x0    <= i_cfg_data;
                CFG_DRIVE_FIRST:   r_iext  <= i_cfg_data;
                CFG_DRIVE_SECOND:  r_iext2 <= i_cfg_data;
                CFG_SLOW_COUPLING: r_ks    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register and valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < TOT; k++) begin
                r_vp[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_in_vld  <= i_s_axis_tvalid;
            r_vp[0]   <= r_in_vld;
            for (int k = 1; k < TOT; k++) begin
                r_vp[k] <= r_vp[k-1];
            end
            r_out_vld <= r_vp[TOT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 6; k++) begin
                r_y[k] <= i_s_axis_tdata[48*k +: 48];
            end
            r_c1 <= i_s_axis_tdata[288 +: 48];
        end
    end

    ehs_deriv #(.FRAC_BITS(FRAC_BITS)) u_der_l (
        .i_clk, .i_en(w_en), .i_y(r_y), .i_c1(r_c1),
        .i_x0(r_x0), .i_iext(r_iext), .i_iext2(r_iext2), .i_ks(r_ks),
        .o_d(dl), .o_ovf(f_d1));

    genvar k;
    generate
        for (k = 0; k < 6; k++) begin : g_lane
            ehs_dly #(.W(48), .D(DER_LAT + ML)) u_dyp (
                .i_clk, .i_en(w_en), .i_d(r_y[k]), .o_q(y_p[k]));
            ehs_dly #(.W(48), .D(TOT)) u_dyc (
                .i_clk, .i_en(w_en), .i_d(r_y[k]), .o_q(y_c[k]));
            ehs_dly #(.W(48), .D(TE)) u_ddl (
                .i_clk, .i_en(w_en), .i_d(dl[k]), .o_q(dl_d[k]));
            ehs_mul #(.W(49), .SH(FRAC_BITS)) u_pm (
                .i_clk, .i_en(w_en), .i_a(w_dt49), .i_b(ext49(dl[k])),
                .o_p(p_prod[k]), .o_ovf(p_o[k]));
            // the sum of the two slopes is exact in 49 bits
            ehs_mul #(.W(49), .SH(FRAC_BITS + 1)) u_cm (
                .i_clk, .i_en(w_en), .i_a(w_dt49), .i_b(ext49(dl_d[k]) + ext49(dr[k])),
                .o_p(c_prod[k]), .o_ovf(c_o[k]));
            assign s_e[k] = sat48(ext52(y_p[k]) + ext52(p_prod[k]));
            assign s_n[k] = sat48(ext52(y_c[k]) + ext52(c_prod[k]));
        end
    endgenerate

    always_comb begin
        f_pred = 1'b0;
        f_corr = 1'b0;
        for (int j = 0; j < 6; j++) begin
            f_pred = f_pred | p_o[j] | s_e[j].o;
            f_corr = f_corr | c_o[j] | s_n[j].o;
        end
    end

    ehs_dly #(.W(1), .D(ML)) u_df1 (.i_clk, .i_en(w_en), .i_d(f_d1), .o_q(f_d1d));

    // euler predictor state
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 6; j++) begin
                r_e[j] <= s_e[j].v;
            end
            r_pf <= f_d1d | f_pred;
        end
    end

    ehs_dly #(.W(48), .D(TE)) u_dc1 (.i_clk, .i_en(w_en), .i_d(r_c1), .o_q(c1_e));

    ehs_deriv #(.FRAC_BITS(FRAC_BITS)) u_der_r (
        .i_clk, .i_en(w_en), .i_y(r_e), .i_c1(c1_e),
        .i_x0(r_x0), .i_iext(r_iext), .i_iext2(r_iext2), .i_ks(r_ks),
        .o_d(dr), .o_ovf(f_pd));

    logic f_pfd;
    ehs_dly #(.W(1), .D(DER_LAT)) u_dpf (.i_clk, .i_en(w_en), .i_d(r_pf), .o_q(f_pfd));
    ehs_dly #(.W(1), .D(ML)) u_dcf (
        .i_clk, .i_en(w_en), .i_d(f_pfd | f_pd), .o_q(f_cd));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 6; j++) begin
                r_next[j] <= s_n[j].v;
            end
            r_ovf <= f_cd | f_corr;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {7'd0, r_ovf, r_next[5], r_next[4], r_next[3],
                              r_next[2], r_next[1], r_next[0]};

endmodule

/* tb/sv/epileptor_heun_step_test.sv */
// self-checking testbench for the epileptor heun step, with its own fixed-point predictor
`timescale 1ns / 1ps

module epileptor_heun_step_test import ehs_pkg::*; ();

    typedef logic signed [127:0] t_wide;

    localparam int     LATENCY   = 76;
    localparam int     LIMIT     = 600000;
    localparam t_wide  Q_MAX     = (t_wide'(1) <<< 47) - 1;
    localparam t_wide  Q_MIN     = -(t_wide'(1) <<< 47);
    localparam t_wide  Q_ONE     = t_wide'(1) <<< 32;
    localparam t_wide  CFG_TOP   = t_wide'(1) <<< 34;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [383:0] s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [295:0] m_data;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [35:0]  cfg_data = '0;

    epileptor_heun_step dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready), .o_m_axis_tdata(m_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [32:0]        step_size  = 33'd214748365;
    logic signed [35:0] excit      = -36'sd6442450944;
    logic signed [35:0] drive_one  = 36'sd13314398618;
    logic signed [35:0] drive_two  = 36'sd1932735283;
    logic signed [35:0] gain_slow  = 36'sd6442450944;

    logic [383:0] pending_nodes[$];
    logic [295:0] expected_steps[$];
    int           failures = 0;
    int           cycles = 0;
    bit           step_ovf;

    // ---------------- fixed point predictor ----------------
    function automatic t_wide sat_q(input t_wide v);
        if (v > Q_MAX) begin
            step_ovf = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            step_ovf = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    // round half toward plus infinity, then saturate
    function automatic t_wide mul_q(input t_wide a, input t_wide b, input int sh);
        t_wide p;
        p = a * b + (t_wide'(1) <<< (sh - 1));
        return sat_q(p >>> sh);
    endfunction

    function automatic t_wide fixq(input t_wide num, input t_wide den);
        return ((num <<< 33) + den) / (2 * den);
    endfunction

    function automatic void rates(input t_wide y[6], input t_wide c1, output t_wide d[6]);
        t_wide k06, k03, k01, k001, krate, quarter, t, p, a, g;
        k06 = fixq(6, 10);
        k03 = fixq(3, 10);
        k01 = fixq(1, 10);
        k001 = fixq(1, 100);
        krate = fixq(35, 100000);
        quarter = t_wide'(1) <<< 30;
        if (y[0] < 0) begin
            t = sat_q(sat_q(3 * y[0]) - mul_q(y[0], y[0], 32));
        end else begin
            p = sat_q(y[2] - 4 * Q_ONE);
            t = sat_q(sat_q(-y[3]) + mul_q(k06, mul_q(p, p, 32), 32));
        end
        d[0] = sat_q(sat_q(sat_q(y[1] - y[2]) + t_wide'(drive_one)) + mul_q(t, y[0], 32));
        d[1] = sat_q(sat_q(Q_ONE - sat_q(5 * mul_q(y[0], y[0], 32))) - y[1]);
        t = 0;
        // seventh power only for negative energy
        if (y[2] < 0) begin
            p = y[2];
            for (int i = 0; i < 6; i++) p = mul_q(p, y[2], 32);
            t = sat_q(-mul_q(k01, p, 32));
        end
        a = sat_q(sat_q(sat_q(4 * sat_q(y[0] - t_wide'(excit))) - y[2]) + t);
        a = sat_q(a + mul_q(t_wide'(gain_slow), c1, 32));
        d[2] = mul_q(krate, a, 32);
        a = sat_q(sat_q(-y[4]) + y[3]);
        a = sat_q(a - mul_q(mul_q(y[3], y[3], 32), y[3], 32));
        a = sat_q(a + t_wide'(drive_two));
        a = sat_q(a + sat_q(2 * y[5]));
        a = sat_q(a - mul_q(k03, sat_q(y[2] - 7 * (t_wide'(1) <<< 31)), 32));
        d[3] = a;
        g = (y[3] < -quarter) ? 0 : sat_q(6 * sat_q(y[3] + quarter));
        d[4] = mul_q(k01, sat_q(sat_q(-y[4]) + g), 32);
        d[5] = sat_q(-mul_q(k001, sat_q(y[5] - mul_q(k01, y[0], 32)), 32));
    endfunction

    function automatic logic [295:0] node_update(input logic [383:0] node);
        t_wide y[6], e[6], dl[6], dr[6];
        t_wide c1, dt;
        logic [295:0] r;
        step_ovf = 1'b0;
        r = '0;
        dt = t_wide'({95'd0, step_size});
        c1 = t_wide'(t_q'(node[6*48 +: 48]));
        for (int i = 0; i < 6; i++) y[i] = t_wide'(t_q'(node[i*48 +: 48]));
        rates(y, c1, dl);
        for (int i = 0; i < 6; i++) e[i] = sat_q(y[i] + mul_q(dt, dl[i], 32));
        rates(e, c1, dr);
        for (int i = 0; i < 6; i++)
            r[i*48 +: 48] = 48'(sat_q(y[i] + mul_q(dt, dl[i] + dr[i], 33)));
        r[288] = step_ovf;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic logic [47:0] rand_full();
        return 48'({$urandom, $urandom});
    endfunction

    // mostly values within a few units, sometimes any pattern
    function automatic logic [47:0] rand_value();
        logic signed [34:0] r;
        if ($urandom_range(0, 7) == 0) return rand_full();
        r = {3'($urandom_range(0, 7)), $urandom};
        if ($urandom_range(0, 3) == 0) return t_q'(r >>> $urandom_range(1, 8));
        return t_q'(r);
    endfunction

    function automatic logic [35:0] rand_cfg();
        logic signed [34:0] r;
        r = {3'($urandom_range(0, 7)), $urandom};
        return 36'(r);
    endfunction

    function automatic logic [383:0] make_node(input logic [47:0] f[8]);
        logic [383:0] n;
        for (int i = 0; i < 8; i++) n[i*48 +: 48] = f[i];
        return n;
    endfunction

    task automatic queue_random(input int count);
        logic [47:0] f[8];
        for (int k = 0; k < count; k++) begin
            for (int i = 0; i < 8; i++) f[i] = rand_value();
            pending_nodes.push_back(make_node(f));
        end
    endtask

    task automatic queue_directed();
        logic [47:0] f[8];
        for (int i = 0; i < 8; i++) f[i] = '0;
        pending_nodes.push_back(make_node(f));
        for (int i = 0; i < 8; i++) f[i] = 48'h7FFFFFFFFFFF;
        pending_nodes.push_back(make_node(f));
        for (int i = 0; i < 8; i++) f[i] = 48'h800000000000;
        pending_nodes.push_back(make_node(f));
        for (int i = 0; i < 8; i++) f[i] = 48'hFFFFFFFFFFFF;
        pending_nodes.push_back(make_node(f));
        // typical resting node, x_one negative
        f = '{-48'sd6442450944, -48'sd42949672960, 48'sd12884901888, -48'sd3435973837,
              48'sd0, -48'sd429496730, 48'sd858993459, 48'sd0};
        pending_nodes.push_back(make_node(f));
        // x_one positive branch
        f[0] = 48'sd4294967296;
        pending_nodes.push_back(make_node(f));
        // negative energy, seventh power
        f[2] = -48'sd4294967296;
        pending_nodes.push_back(make_node(f));
        f[2] = -48'sd12884901888;
        pending_nodes.push_back(make_node(f));
        // x_two exactly at the rectifier corner and just below it
        f[3] = -48'sd1073741824;
        pending_nodes.push_back(make_node(f));
        f[3] = -48'sd1073741825;
        pending_nodes.push_back(make_node(f));
        // second coupling at its extremes has no effect
        f[7] = 48'h7FFFFFFFFFFF;
        pending_nodes.push_back(make_node(f));
        f[7] = 48'h800000000000;
        pending_nodes.push_back(make_node(f));
        for (int i = 0; i < 8; i++) f[i] = '0;
        f[6] = 48'h7FFFFFFFFFFF;
        pending_nodes.push_back(make_node(f));
        f[6] = 48'h800000000000;
        pending_nodes.push_back(make_node(f));
        for (int j = 0; j < 6; j++) begin
            for (int i = 0; i < 8; i++) f[i] = '0;
            f[j] = (j % 2) ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
            pending_nodes.push_back(make_node(f));
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_nodes.size() != 0 || s_valid || expected_steps.size() != 0);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [35:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge i_clk);
        while (!cfg_ready);
        case (idx)
            CFG_TIME_STEP:     step_size = value[32:0];
            CFG_EXCITABILITY:  excit = value;
            CFG_DRIVE_FIRST:   drive_one = value;
            CFG_DRIVE_SECOND:  drive_two = value;
            CFG_SLOW_COUPLING: gain_slow = value;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [35:0] dt, input logic [35:0] x0,
                             input logic [35:0] i1, input logic [35:0] i2,
                             input logic [35:0] ks);
        write_reg(CFG_TIME_STEP, dt);
        write_reg(CFG_EXCITABILITY, x0);
        write_reg(CFG_DRIVE_FIRST, i1);
        write_reg(CFG_DRIVE_SECOND, i2);
        write_reg(CFG_SLOW_COUPLING, ks);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------- driver ----------------
    int gap_left = 0;
    bit send_burst = 1'b0;

    always @(posedge i_clk) begin
        bit next_valid;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                expected_steps.push_back(node_update(s_data));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_nodes.size() != 0) begin
                    s_data <= pending_nodes.pop_front();
                    next_valid = 1'b1;
                    if ($urandom_range(0, 39) == 0) send_burst <= !send_burst;
                    gap_left <= send_burst ? 0 : $urandom_range(0, 13);
                end
            end
            s_valid <= next_valid;
        end
    end

    // ---------------- monitor ----------------
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  recv_burst = 1'b0;
    int  received = 0;

    // one long hold-off so the pipeline fills and stalls the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (received == 300 && !hold_done) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic [295:0] want;
        bit next_ready;
        int draw;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            next_ready = m_ready;
            if (m_valid && m_ready) begin
                received <= received + 1;
                if (expected_steps.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %h", $time, m_data);
                    failures++;
                end else begin
                    want = expected_steps.pop_front();
                    for (int i = 0; i < 6; i++)
                        if (m_data[i*48 +: 48] !== want[i*48 +: 48]) begin
                            $display("%0t: field %0d expected %h actual %h", $time, i,
                                     want[i*48 +: 48], m_data[i*48 +: 48]);
                            failures++;
                        end
                    if (m_data[288] !== want[288]) begin
                        $display("%0t: overflow expected %b actual %b", $time,
                                 want[288], m_data[288]);
                        failures++;
                    end
                end
                if ($urandom_range(0, 39) == 0) recv_burst <= !recv_burst;
                draw = recv_burst ? 0 : $urandom_range(0, 13);
                stall_left <= draw;
                next_ready = (draw == 0);
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            if (hold_left > 0) next_ready = 1'b0;
            m_ready <= next_ready;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- sequence of phases ----------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        queue_directed();
        queue_random(330);
        wait_drained();
        write_all(36'd429496730, rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg());
        queue_random(300);
        wait_drained();
        // unit step and a value of four in every other register
        write_all(36'h100000000, 36'(CFG_TOP), 36'(CFG_TOP), 36'(CFG_TOP), 36'(CFG_TOP));
        queue_directed();
        queue_random(220);
        wait_drained();
        write_all(36'd1, 36'(-CFG_TOP), 36'(-CFG_TOP), 36'(-CFG_TOP), 36'(-CFG_TOP));
        queue_random(220);
        wait_drained();
        // zero step leaves the state as it is
        write_all(36'd0, rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg());
        queue_random(100);
        wait_drained();
        write_all(36'($urandom_range(1, 32'hFFFFFFFF)), rand_cfg(), rand_cfg(),
                  rand_cfg(), rand_cfg());
        queue_random(300);
        wait_drained();
        write_all(36'({$urandom_range(0, 1), $urandom} | 33'd1), rand_cfg(), rand_cfg(),
                  rand_cfg(), rand_cfg());
        queue_random(200);
        wait_drained();
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
